// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the bit chunk lane splitter.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define BCLS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bcls assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define BCLS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bcls assertion failed");
`else
`define BCLS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BCLS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== src/bcls_pkg.sv =====
// Package of the bit chunk lane splitter: sizes, register indexes,
// controller commands and status. No dependencies.
package bcls_pkg;

   // Sizes of the block.
   localparam int unsigned MAX_LANES      = 16;
   localparam int unsigned MAX_CHUNK_BITS = 32;
   localparam int unsigned BYTE_W         = 8;
   localparam int unsigned LANE_W         = $clog2(MAX_LANES);
   localparam int unsigned CW_W           = 6;
   localparam int unsigned LC_W           = 5;
   localparam int unsigned EN_W           = 16;
   localparam int unsigned BLOCK_W        = MAX_CHUNK_BITS + BYTE_W;
   localparam int unsigned LEVEL_W        = $clog2(BLOCK_W);
   localparam int unsigned IDX_W          = LANE_W + 1;
   localparam int unsigned CNT_W          = 3;
   localparam int unsigned ACC_W          = MAX_CHUNK_BITS + BYTE_W - 1;
   localparam int unsigned TOTAL_W        = $clog2(ACC_W + 1);

   // Configuration port.
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = EN_W;
   localparam logic [CSR_IDX_W-1:0] REG_CHUNK_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LANE_COUNT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LANE_ENABLE = 2'd2;
   localparam logic [CW_W-1:0]      CHUNK_WIDTH_RST = 6'd8;
   localparam logic [LC_W-1:0]      LANE_COUNT_RST  = 5'd1;
   localparam logic [EN_W-1:0]      LANE_ENABLE_RST = 16'd1;

   // Datapath operations issued by the controller.
   typedef logic [2:0] op_type;
   localparam op_type OP_NONE  = 3'd0;
   localparam op_type OP_LOAD  = 3'd1;
   localparam op_type OP_TAKE  = 3'd2;
   localparam op_type OP_EMIT  = 3'd3;
   localparam op_type OP_STORE = 3'd4;
   localparam op_type OP_FSCAN = 3'd5;
   localparam op_type OP_DFIN  = 3'd6;
   localparam op_type OP_FFIN  = 3'd7;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic chunk_avail;
      logic lane_on;
      logic total_ge8;
      logic scan_step;
      logic scan_last;
      logic fin_ok;
   } sts_type;

endpackage

// ===== src/bcls_req_if.sv =====
// Input channel of the bit chunk lane splitter: valid, ready and one word.
// No dependencies.
interface bcls_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] data_byte;

   modport source (output valid, output action, output data_byte, input ready);
   modport sink   (input valid, input action, input data_byte, output ready);
endinterface

// ===== src/bcls_rsp_if.sv =====
// Result channel of the bit chunk lane splitter: valid, ready and one word.
// No dependencies.
interface bcls_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] lane;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, output lane, output out_byte, output last, input ready);
   modport sink   (input valid, input lane, input out_byte, input last, output ready);
endinterface

// ===== src/bcls_ctrl.sv =====
// Controller state machine of the bit chunk lane splitter.
// Depends on bcls_pkg; drives the datapath bcls_dp through cmd/sts.
module bcls_ctrl
   import bcls_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_action,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHUNK = 3'd1;
   localparam logic [2:0] ST_EMIT  = 3'd2;
   localparam logic [2:0] ST_FSCAN = 3'd3;
   localparam logic [2:0] ST_DFIN  = 3'd4;
   localparam logic [2:0] ST_FFIN  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // A word is taken only when no earlier word is still being worked on.
   assign req_ready = (state_ff == ST_IDLE);

   // Next state and datapath command.
   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_action) begin
                  state_in = ST_FSCAN;
               end else begin
                  cmd.op   = OP_LOAD;
                  state_in = ST_CHUNK;
               end
            end
         end
         ST_CHUNK: begin
            if (sts.chunk_avail) begin
               cmd.op = OP_TAKE;
               if (sts.lane_on) begin
                  state_in = ST_EMIT;
               end
            end else begin
               state_in = ST_DFIN;
            end
         end
         ST_EMIT: begin
            if (sts.total_ge8) begin
               cmd.op = OP_EMIT;
            end else begin
               cmd.op   = OP_STORE;
               state_in = ST_CHUNK;
            end
         end
         ST_FSCAN: begin
            cmd.op = OP_FSCAN;
            if (sts.scan_step && sts.scan_last) begin
               state_in = ST_FFIN;
            end
         end
         ST_DFIN: begin
            cmd.op = OP_DFIN;
            if (sts.fin_ok) begin
               state_in = ST_IDLE;
            end
         end
         ST_FFIN: begin
            cmd.op = OP_FFIN;
            if (sts.fin_ok) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/bcls_dp.sv =====
// Datapath of the bit chunk lane splitter: configuration registers, block
// bit buffer, per-lane partial bytes, hold stage and output register.
// Depends on bcls_pkg; commanded by bcls_ctrl.
module bcls_dp
   import bcls_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic [BYTE_W-1:0]     req_data_byte,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [LANE_W-1:0]     rsp_lane,
   output logic [BYTE_W-1:0]     rsp_out_byte,
   output logic                  rsp_last
);

   localparam logic [MAX_CHUNK_BITS-1:0] CHUNK_ONES = {MAX_CHUNK_BITS{1'b1}};

   // Configuration.
   logic [CW_W-1:0] cw_ff, cw_in;
   logic [LC_W-1:0] lc_ff, lc_in;
   logic [EN_W-1:0] en_ff, en_in;

   // Block buffer and chunk position.
   logic [BLOCK_W-1:0] bits_ff, bits_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;

   // Per-lane partial bytes.
   logic [BYTE_W-1:0] pend_bits_ff [MAX_LANES];
   logic [BYTE_W-1:0] pend_bits_in [MAX_LANES];
   logic [CNT_W-1:0]  pend_cnt_ff  [MAX_LANES];
   logic [CNT_W-1:0]  pend_cnt_in  [MAX_LANES];

   // Lane accumulator of the chunk being packed.
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [LANE_W-1:0]  cur_lane_ff, cur_lane_in;

   // Flush scan position.
   logic [LANE_W-1:0] scan_ff, scan_in;

   // Hold stage: the newest result, kept back until it is known whether it ends the word.
   logic              hold_valid_ff, hold_valid_in;
   logic [LANE_W-1:0] hold_lane_ff, hold_lane_in;
   logic [BYTE_W-1:0] hold_byte_ff, hold_byte_in;

   // Output register.
   logic              out_valid_ff, out_valid_in;
   logic [LANE_W-1:0] out_lane_ff, out_lane_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;

   logic [CW_W-1:0]           w_eff;
   logic [LC_W-1:0]           lanes_eff;
   logic [LANE_W-1:0]         rd_addr;
   logic [BYTE_W-1:0]         rd_bits;
   logic [CNT_W-1:0]          rd_cnt;
   logic [MAX_CHUNK_BITS-1:0] chunk;
   logic [ACC_W-1:0]          acc_take;
   logic [TOTAL_W-1:0]        total_take;
   logic                      can_push;
   logic                      push_ok;
   logic                      scan_want;
   logic                      new_valid;
   logic [LANE_W-1:0]         new_lane;
   logic [BYTE_W-1:0]         new_byte;

   // Effective chunk width and lane count, with out-of-range values clamped.
   always_comb begin
      if (cw_ff == '0) begin
         w_eff = CW_W'(1);
      end else if (cw_ff > CW_W'(MAX_CHUNK_BITS)) begin
         w_eff = CW_W'(MAX_CHUNK_BITS);
      end else begin
         w_eff = cw_ff;
      end
      if (lc_ff == '0) begin
         lanes_eff = LC_W'(1);
      end else if (lc_ff > LC_W'(MAX_LANES)) begin
         lanes_eff = LC_W'(MAX_LANES);
      end else begin
         lanes_eff = lc_ff;
      end
   end

   // One read port on the partial bytes: the scan position during a flush,
   // the current chunk position otherwise.
   assign rd_addr = (cmd.op == OP_FSCAN) ? scan_ff : idx_ff[LANE_W-1:0];
   assign rd_bits = pend_bits_ff[rd_addr];
   assign rd_cnt  = pend_cnt_ff[rd_addr];

   // Next chunk of the block and its merge with the lane's partial byte.
   assign chunk      = bits_ff[MAX_CHUNK_BITS-1:0]
                       & (CHUNK_ONES >> (CW_W'(MAX_CHUNK_BITS) - w_eff));
   assign acc_take   = ACC_W'(rd_bits) | (ACC_W'(chunk) << rd_cnt);
   assign total_take = TOTAL_W'(rd_cnt) + TOTAL_W'(w_eff);

   // A new result may enter the hold stage if it is empty or can move on.
   assign can_push  = !out_valid_ff || rsp_ready;
   assign push_ok   = !hold_valid_ff || can_push;
   assign scan_want = en_ff[scan_ff] && (rd_cnt != '0);

   // Result produced in this cycle.
   always_comb begin
      new_valid = 1'b0;
      new_lane  = cur_lane_ff;
      new_byte  = acc_ff[BYTE_W-1:0];
      if (cmd.op == OP_EMIT) begin
         new_valid = push_ok;
      end else if (cmd.op == OP_FSCAN) begin
         new_valid = scan_want && push_ok;
         new_lane  = scan_ff;
         new_byte  = rd_bits;
      end
   end

   // Status towards the controller.
   always_comb begin
      sts.chunk_avail = (idx_ff < IDX_W'(lanes_eff)) && (level_ff >= LEVEL_W'(w_eff));
      sts.lane_on     = en_ff[idx_ff[LANE_W-1:0]];
      sts.total_ge8   = (total_ff >= TOTAL_W'(BYTE_W));
      sts.scan_step   = !scan_want || push_ok;
      sts.scan_last   = (scan_ff == LANE_W'(MAX_LANES - 1));
      sts.fin_ok      = !hold_valid_ff || can_push;
   end

   // Next values of all registers.
   always_comb begin
      cw_in         = cw_ff;
      lc_in         = lc_ff;
      en_in         = en_ff;
      bits_in       = bits_ff;
      level_in      = level_ff;
      idx_in        = idx_ff;
      pend_bits_in  = pend_bits_ff;
      pend_cnt_in   = pend_cnt_ff;
      acc_in        = acc_ff;
      total_in      = total_ff;
      cur_lane_in   = cur_lane_ff;
      scan_in       = scan_ff;
      hold_valid_in = hold_valid_ff;
      hold_lane_in  = hold_lane_ff;
      hold_byte_in  = hold_byte_ff;
      out_valid_in  = out_valid_ff;
      out_lane_in   = out_lane_ff;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;

      // Register writes; indexes beyond the list are ignored.
      if (csr_we) begin
         unique case (csr_index)
            REG_CHUNK_WIDTH: cw_in = csr_data[CW_W-1:0];
            REG_LANE_COUNT:  lc_in = csr_data[LC_W-1:0];
            REG_LANE_ENABLE: en_in = csr_data[EN_W-1:0];
            default: ;
         endcase
      end

      // Block buffer, accumulator and partial bytes.
      case (cmd.op)
         OP_LOAD: begin
            bits_in  = bits_ff | (BLOCK_W'(req_data_byte) << level_ff);
            level_in = level_ff + LEVEL_W'(BYTE_W);
         end
         OP_TAKE: begin
            bits_in     = bits_ff >> w_eff;
            level_in    = level_ff - LEVEL_W'(w_eff);
            idx_in      = idx_ff + IDX_W'(1);
            acc_in      = acc_take;
            total_in    = total_take;
            cur_lane_in = idx_ff[LANE_W-1:0];
         end
         OP_EMIT: begin
            if (push_ok) begin
               acc_in   = acc_ff >> BYTE_W;
               total_in = total_ff - TOTAL_W'(BYTE_W);
            end
         end
         OP_STORE: begin
            pend_bits_in[cur_lane_ff] = acc_ff[BYTE_W-1:0];
            pend_cnt_in[cur_lane_ff]  = total_ff[CNT_W-1:0];
         end
         OP_FSCAN: begin
            if (sts.scan_step) begin
               scan_in = sts.scan_last ? '0 : scan_ff + LANE_W'(1);
            end
         end
         OP_DFIN: begin
            // A completed block drops its leftover bits.
            if (idx_ff >= IDX_W'(lanes_eff)) begin
               bits_in  = '0;
               level_in = '0;
               idx_in   = '0;
            end
         end
         OP_FFIN: begin
            bits_in      = '0;
            level_in     = '0;
            idx_in       = '0;
            scan_in      = '0;
            pend_bits_in = '{default: '0};
            pend_cnt_in  = '{default: '0};
         end
         default: ;
      endcase

      // Output register drains when the receiver takes the word.
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      // A new result pushes the held one out, which is then not the last.
      if (new_valid) begin
         if (hold_valid_ff) begin
            out_valid_in = 1'b1;
            out_lane_in  = hold_lane_ff;
            out_byte_in  = hold_byte_ff;
            out_last_in  = 1'b0;
         end
         hold_valid_in = 1'b1;
         hold_lane_in  = new_lane;
         hold_byte_in  = new_byte;
      end

      // At the end of the word the held result goes out marked last.
      if (((cmd.op == OP_DFIN) || (cmd.op == OP_FFIN)) && hold_valid_ff && can_push) begin
         out_valid_in  = 1'b1;
         out_lane_in   = hold_lane_ff;
         out_byte_in   = hold_byte_ff;
         out_last_in   = 1'b1;
         hold_valid_in = 1'b0;
      end
   end

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         cw_ff         <= CHUNK_WIDTH_RST;
         lc_ff         <= LANE_COUNT_RST;
         en_ff         <= LANE_ENABLE_RST;
         bits_ff       <= '0;
         level_ff      <= '0;
         idx_ff        <= '0;
         pend_bits_ff  <= '{default: '0};
         pend_cnt_ff   <= '{default: '0};
         scan_ff       <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         cw_ff         <= cw_in;
         lc_ff         <= lc_in;
         en_ff         <= en_in;
         bits_ff       <= bits_in;
         level_ff      <= level_in;
         idx_ff        <= idx_in;
         pend_bits_ff  <= pend_bits_in;
         pend_cnt_ff   <= pend_cnt_in;
         scan_ff       <= scan_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      total_ff     <= total_in;
      cur_lane_ff  <= cur_lane_in;
      hold_lane_ff <= hold_lane_in;
      hold_byte_ff <= hold_byte_in;
      out_lane_ff  <= out_lane_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_lane     = out_lane_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_last     = out_last_ff;

endmodule

// ===== src/bit_chunk_lane_splitter_unit.sv =====
// Bit chunk lane splitter: a byte stream is cut into chunks per lane and
// repacked into bytes per lane. Input word: action and data_byte on req_ch.
// Result word: lane, out_byte and last on rsp_ch; last marks the final
// result caused by one input word. Registers chunk_width (index 0),
// lane_count (1) and lane_enable (2) are written through csr_we, csr_index
// and csr_data; the user must write them only while the block is idle,
// which the block itself does not enforce. Words are taken one at a time:
// req_ch.ready is high only while no word is in progress. A data word loads
// its byte, takes each chunk it completes and, for each chunk of an enabled
// lane, emits one result per lane byte it fills and stores the rest. The
// first result reaches the output register within its chunk when the chunk
// fills two lane bytes, otherwise with the next result or at the end of the
// word. A flush scans the 16 lane partial bytes and emits each filled one
// of an enabled lane.
// Each result sits in a one-word hold stage until the next one appears or
// the word ends, then moves to the output register, so a new word can be
// taken while the last result still waits. A stalled receiver holds the
// block in its current step. Synchronous reset restores the register
// defaults, clears all lane and block state and empties the output.
`include "assert_macros.svh"

module bit_chunk_lane_splitter_unit
   import bcls_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   bcls_req_if.sink              req_ch,
   bcls_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   // Sequencer.
   bcls_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_action (req_ch.action),
      .req_ready  (req_ch.ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Bit buffer, lane packing and result registers.
   bcls_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_data_byte (req_ch.data_byte),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_lane      (rsp_ch.lane),
      .rsp_out_byte  (rsp_ch.out_byte),
      .rsp_last      (rsp_ch.last)
   );

   // Checks on the sequencing.
   `BCLS_ASSERT_NXT(a_busy_after_accept, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready)
   `BCLS_ASSERT_IMP(a_take_has_chunk, clock, reset, cmd.op == OP_TAKE, sts.chunk_avail)
   `BCLS_ASSERT_IMP(a_emit_has_byte, clock, reset, cmd.op == OP_EMIT, sts.total_ge8)
   `BCLS_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_ch.valid && req_ch.ready)

endmodule

// ===== verif/tb_bit_chunk_lane_splitter_unit.sv =====
// Self-checking testbench of bit_chunk_lane_splitter_unit: a directed table, then random phases.
// Depends on bcls_pkg and the bcls_req_if and bcls_rsp_if interfaces of the RTL.
// Every result word is checked against a predictor of the chunk splitting and lane packing or against a typed value.
module tb_bit_chunk_lane_splitter_unit;
   import bcls_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic ACT_DATA  = 1'b0;
   localparam logic ACT_FLUSH = 1'b1;

   localparam int IDLE_PCT    = 28;
   localparam int SETTLE      = 64;
   localparam int STALL_LIMIT = 4000;
   localparam int RAND_ITEMS  = 140;
   localparam int MAX_PHASES  = 60;
   localparam int REPORT_MAX  = 10;
   localparam int NROWS       = 29;

   typedef struct packed {
      logic       action;
      logic [7:0] data;
   } req_word_type;

   typedef struct packed {
      logic [3:0] lane;
      logic [7:0] octet;
      logic       last;
   } lane_byte_type;

   typedef enum logic [1:0] {ROW_REG, ROW_WORD} row_kind_type;
   typedef enum logic [1:0] {CHK_MODEL, CHK_ONE, CHK_NONE} row_check_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] value;
      logic                  action;
      logic [7:0]            data;
      row_check_type         check;
      logic [3:0]            lane;
      logic [7:0]            octet;
   } dir_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   bcls_req_if req_ch ();
   bcls_rsp_if rsp_ch ();

   bit quiet = 1'b0;
   int errors = 0;
   int words_queued = 0;
   int words_taken = 0;

   req_word_type  word_q[$];
   lane_byte_type lane_bytes_due[$];
   lane_byte_type fresh_q[$];

   // Register mirror and state of the predictor.
   logic [CW_W-1:0] cfg_width  = CHUNK_WIDTH_RST;
   logic [LC_W-1:0] cfg_lanes  = LANE_COUNT_RST;
   logic [EN_W-1:0] cfg_enable = LANE_ENABLE_RST;
   logic [63:0]     blk_bits;
   int              blk_level;
   int              chunk_pos;
   logic [7:0]      lane_acc [MAX_LANES];
   int              lane_fill [MAX_LANES];

   // Directed stimulus. Expected words are typed in only where they are obvious.
   dir_row_type dir_rows [NROWS] = '{
      // Reset settings: one lane of 8-bit chunks passes bytes straight through.
      '{ROW_WORD, REG_CHUNK_WIDTH, 16'h0, ACT_DATA,  8'h00, CHK_ONE,   4'd0, 8'h00},
      '{ROW_WORD, REG_CHUNK_WIDTH, 16'h0, ACT_DATA,  8'hFF, CHK_ONE,   4'd0, 8'hFF},
      '{ROW_WORD, REG_CHUNK_WIDTH, 16'h0, ACT_DATA,  8'hA5, CHK_ONE,   4'd0, 8'hA5},
      '{ROW_WORD, REG_CHUNK_WIDTH, 16'h0, ACT_FLUSH, 8'h00, CHK_NONE,  4'd0, 8'h00},
      // Zero width and zero count act as one: a single bit per byte reaches lane 0.
      '{ROW_REG,  REG_CHUNK_WIDTH, 16'd0, ACT_DATA,  8'h00, CHK_MODEL, 4'd0, 8'h00},
      '{ROW_REG,  REG_LANE_COUNT,  16'd0, ACT_DATA,  8'h00, CHK_MODEL, 4'd0, 8'h00},
      '{ROW_WORD, REG_CHUNK_WIDTH, 16'h0, ACT_DATA,  8'h5A, CHK_NONE,  4'd0, 8'h00},
      '{ROW_WORD, REG_CHUNK_WIDTH, 16'h0, ACT_FLUSH, 8'h00, CHK_ONE,   4'd0, 8'h00},
      // All lanes disabled: nothing comes out, not even on a flush.
      '{ROW_REG,  REG_LANE_ENABLE, 16'h0, ACT_DATA,  8'h00, CHK_MODEL, 4'd0, 8'h00},
      '{ROW_WORD, REG_CHUNK_WIDTH, 16'h0, ACT_DATA,  8'hFF, CHK_NONE,  4'd0, 8'h00},
      '{ROW_WORD, REG_CHUNK_WIDTH, 16'h0, ACT_FLUSH, 8'hFF, CHK_NONE,  4'd0, 8'h00},
      // Oversized width and count clamp to the widest chunk and all sixteen lanes.
      '{ROW_REG,  REG_CHUNK_WIDTH, 16'd63, ACT_DATA, 8'h00, CHK_MODEL, 4'd0, 8'h00},
      '{ROW_REG,  REG_LANE_COUNT,  16'd31, ACT_DATA, 8'h00, CHK_MODEL, 4'd0, 8'h00},
      '{ROW_REG,  REG_LANE_ENABLE, 16'hFFFF, ACT_DATA, 8'h00, CHK_MODEL, 4'd0, 8'h00},
      '{ROW_WORD, REG_CHUNK_WIDTH, 16'h0, ACT_DATA,  8'h01, CHK_MODEL, 4'd0, 8'h00},
      '{ROW_WORD, REG_CHUNK_WIDTH, 16'h0, ACT_DATA,  8'h80, CHK_MODEL, 4'd0, 8'h00},
      '{ROW_WORD, REG_CHUNK_WIDTH, 16'h0, ACT_DATA,  8'h7E, CHK_MODEL, 4'd0, 8'h00},
      '{ROW_WORD, REG_CHUNK_WIDTH, 16'h0, ACT_DATA,  8'hC3, CHK_MODEL, 4'd0, 8'h00},
      '{ROW_WORD, REG_CHUNK_WIDTH, 16'h0, ACT_DATA,  8'h3C, CHK_MODEL, 4'd0, 8'h00},
      '{ROW_WORD, REG_CHUNK_WIDTH, 16'h0, ACT_FLUSH, 8'h00, CHK_MODEL, 4'd0, 8'h00},
      // Odd width with some lanes off, leftover bits dropped at each block end.
      '{ROW_REG,  REG_CHUNK_WIDTH, 16'd3, ACT_DATA,  8'h00, CHK_MODEL, 4'd0, 8'h00},
      '{ROW_REG,  REG_LANE_COUNT,  16'd5, ACT_DATA,  8'h00, CHK_MODEL, 4'd0, 8'h00},
      '{ROW_REG,  REG_LANE_ENABLE, 16'h0015, ACT_DATA, 8'h00, CHK_MODEL, 4'd0, 8'h00},
      '{ROW_WORD, REG_CHUNK_WIDTH, 16'h0, ACT_DATA,  8'h96, CHK_MODEL, 4'd0, 8'h00},
      '{ROW_WORD, REG_CHUNK_WIDTH, 16'h0, ACT_DATA,  8'h69, CHK_MODEL, 4'd0, 8'h00},
      '{ROW_WORD, REG_CHUNK_WIDTH, 16'h0, ACT_DATA,  8'h33, CHK_MODEL, 4'd0, 8'h00},
      // Lane count lowered mid block to the chunk position: the block ends.
      '{ROW_REG,  REG_LANE_COUNT,  16'd2, ACT_DATA,  8'h00, CHK_MODEL, 4'd0, 8'h00},
      '{ROW_WORD, REG_CHUNK_WIDTH, 16'h0, ACT_DATA,  8'hF0, CHK_MODEL, 4'd0, 8'h00},
      '{ROW_WORD, REG_CHUNK_WIDTH, 16'h0, ACT_FLUSH, 8'h00, CHK_MODEL, 4'd0, 8'h00}
   };

   bit_chunk_lane_splitter_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic void note_error(input string msg);
      errors++;
      if (errors <= REPORT_MAX) begin
         $display("%0t: %s", $realtime, msg);
      end
   endfunction

   function automatic void clear_split_state();
      blk_bits  = '0;
      blk_level = 0;
      chunk_pos = 0;
      for (int k = 0; k < MAX_LANES; k++) begin
         lane_acc[k]  = '0;
         lane_fill[k] = 0;
      end
   endfunction

   // Predictor: cuts the bit stream into chunks and packs each lane's chunks into bytes.
   // The lane bytes caused by one input word are left in fresh_q.
   function automatic void split_and_pack(input logic act, input logic [7:0] dbyte);
      int            w;
      int            lanes;
      int            k;
      int            total;
      logic [63:0]   mask;
      logic [63:0]   chunk;
      logic [63:0]   acc;
      lane_byte_type tail;
      fresh_q.delete();
      if (act == ACT_FLUSH) begin
         for (k = 0; k < MAX_LANES; k++) begin
            if (cfg_enable[k] && lane_fill[k] != 0 && fresh_q.size() < MAX_LANES) begin
               fresh_q.push_back('{4'(k), lane_acc[k], 1'b0});
            end
         end
         clear_split_state();
      end else begin
         w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_CHUNK_BITS) ? MAX_CHUNK_BITS : cfg_width);
         lanes = (cfg_lanes == 0) ? 1 : ((cfg_lanes > MAX_LANES) ? MAX_LANES : cfg_lanes);
         mask = (64'd1 << w) - 64'd1;
         blk_bits |= 64'(dbyte) << blk_level;
         blk_level += 8;
         while (chunk_pos < lanes && blk_level >= w) begin
            chunk = blk_bits & mask;
            k = chunk_pos;
            blk_bits >>= w;
            blk_level -= w;
            chunk_pos++;
            // A disabled lane loses its chunk and keeps its partial byte.
            if (cfg_enable[k]) begin
               acc = 64'(lane_acc[k]) | (chunk << lane_fill[k]);
               total = lane_fill[k] + w;
               while (total >= 8) begin
                  if (fresh_q.size() < MAX_LANES) begin
                     fresh_q.push_back('{4'(k), acc[7:0], 1'b0});
                  end
                  acc >>= 8;
                  total -= 8;
               end
               lane_acc[k]  = acc[7:0];
               lane_fill[k] = total;
            end
         end
         // End of block: the rest of the completing byte is dropped.
         if (chunk_pos >= lanes) begin
            blk_bits  = '0;
            blk_level = 0;
            chunk_pos = 0;
         end
      end
      if (fresh_q.size() != 0) begin
         tail = fresh_q.pop_back();
         tail.last = 1'b1;
         fresh_q.push_back(tail);
      end
   endfunction

   // Queues one input word and the lane bytes it must cause.
   function automatic void queue_word(input logic act, input logic [7:0] dbyte,
                                      input row_check_type check, input logic [3:0] lane,
                                      input logic [7:0] octet);
      split_and_pack(act, dbyte);
      case (check)
         CHK_ONE: begin
            lane_bytes_due.push_back('{lane, octet, 1'b1});
         end
         CHK_NONE: begin
         end
         default: begin
            foreach (fresh_q[j]) begin
               lane_bytes_due.push_back(fresh_q[j]);
            end
         end
      endcase
      word_q.push_back('{act, dbyte});
      words_queued++;
   endfunction

   // Waits until every word is taken and every lane byte has come, then lets the block settle.
   task automatic wait_idle();
      while (words_taken != words_queued || lane_bytes_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_CHUNK_WIDTH: cfg_width  = val[CW_W-1:0];
         REG_LANE_COUNT:  cfg_lanes  = val[LC_W-1:0];
         REG_LANE_ENABLE: cfg_enable = val[EN_W-1:0];
         default: begin
         end
      endcase
   endtask

   // Input side: present queued words, idling at random unless in a quiet stretch.
   always @(posedge clock) begin : req_drive
      req_word_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            words_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (word_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
               nxt = word_q.pop_front();
               req_ch.valid     <= 1'b1;
               req_ch.action    <= nxt.action;
               req_ch.data_byte <= nxt.data;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Result side: random stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Compare each lane byte taken with the oldest one due.
   always @(posedge clock) begin : rsp_check
      lane_byte_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (lane_bytes_due.size() == 0) begin
            note_error($sformatf("lane byte with nothing due: lane %0d byte %02h last %0b",
                                 rsp_ch.lane, rsp_ch.out_byte, rsp_ch.last));
         end else begin
            want = lane_bytes_due.pop_front();
            if (rsp_ch.lane !== want.lane || rsp_ch.out_byte !== want.octet ||
                rsp_ch.last !== want.last) begin
               note_error($sformatf(
                  "lane byte mismatch: expected lane %0d byte %02h last %0b, got lane %0d byte %02h last %0b",
                  want.lane, want.octet, want.last, rsp_ch.lane, rsp_ch.out_byte, rsp_ch.last));
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a word.
   always @(posedge clock) begin : watchdog
      int stalled;
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stalled = 0;
      end else begin
         stalled++;
         if (stalled >= STALL_LIMIT) begin
            $display("tb_bit_chunk_lane_splitter_unit: done, errors");
            $finish;
         end
      end
   end

   initial begin : main
      int          phase;
      int          nwords;
      int          rand_words;
      logic [15:0] cw;
      logic [15:0] lc;
      logic [15:0] en;
      req_ch.valid     = 1'b0;
      req_ch.action    = ACT_DATA;
      req_ch.data_byte = '0;
      rsp_ch.ready     = 1'b0;
      clear_split_state();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table.
      foreach (dir_rows[r]) begin
         if (dir_rows[r].kind == ROW_REG) begin
            wait_idle();
            write_reg(dir_rows[r].idx, dir_rows[r].value);
         end else begin
            queue_word(dir_rows[r].action, dir_rows[r].data, dir_rows[r].check,
                       dir_rows[r].lane, dir_rows[r].octet);
         end
      end

      // Random phases: new settings between phases, no flush forced at the change,
      // so settings also change in the middle of a block.
      phase = 0;
      rand_words = 0;
      while (rand_words < RAND_ITEMS && phase < MAX_PHASES) begin
         case ($urandom_range(5))
            0:       cw = 16'd1;
            1:       cw = 16'(MAX_CHUNK_BITS);
            2:       cw = $urandom_range(1) ? 16'd0 : 16'($urandom_range(63, 33));
            default: cw = 16'($urandom_range(12, 1));
         endcase
         case ($urandom_range(5))
            0:       lc = 16'd1;
            1:       lc = 16'(MAX_LANES);
            2:       lc = $urandom_range(1) ? 16'd0 : 16'($urandom_range(31, 17));
            default: lc = 16'($urandom_range(8, 1));
         endcase
         case ($urandom_range(5))
            0:       en = 16'hFFFF;
            1:       en = 16'h0000;
            2:       en = 16'h0001 << $urandom_range(15);
            default: en = 16'($urandom);
         endcase
         wait_idle();
         quiet = 1'b0;
         if ($urandom_range(3) != 0) write_reg(REG_CHUNK_WIDTH, cw);
         if ($urandom_range(3) != 0) write_reg(REG_LANE_COUNT, lc);
         if ($urandom_range(3) != 0) write_reg(REG_LANE_ENABLE, en);
         // One long phase without any idling on either side.
         quiet = (phase == 2);
         nwords = quiet ? 40 : $urandom_range(24, 12);
         repeat (nwords) begin
            if ($urandom_range(99) < 8) begin
               queue_word(ACT_FLUSH, 8'($urandom), CHK_MODEL, 4'd0, 8'h00);
            end else begin
               queue_word(ACT_DATA, 8'($urandom), CHK_MODEL, 4'd0, 8'h00);
            end
         end
         rand_words += nwords;
         phase++;
      end

      wait_idle();
      if (errors == 0 && lane_bytes_due.size() == 0) begin
         $display("tb_bit_chunk_lane_splitter_unit: done, clean");
      end else begin
         $display("tb_bit_chunk_lane_splitter_unit: done, errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/bcls_pkg.sv
src/bcls_req_if.sv
src/bcls_rsp_if.sv
src/bcls_ctrl.sv
src/bcls_dp.sv
src/bit_chunk_lane_splitter_unit.sv
verif/tb_bit_chunk_lane_splitter_unit.sv
